/* design/eske_pkg.sv */
// ----------------------------------------------------------------------------
// eske_pkg: shared types and constants of the encoder speed estimator
// Holds the controller/datapath command and status words, the result word
// layout and the fixed constants of the M/T speed and Kalman arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eske_pkg;

	// 60e6 / 4 quadrature edges = 15e6, times 256 for the Q8.8 gear divisor.
	localparam logic [31:0] RPM_NUM = 32'd3840000000;
	// round(pi / 30 * 2^32)
	localparam logic [28:0] PI_OVER_30_Q32 = 29'd449767923;

	localparam logic [31:0] VAR_RESET  = 32'd256000;
	localparam logic [15:0] PPR_RESET  = 16'd1000;
	localparam logic [15:0] GEAR_RESET = 16'd256;
	localparam logic [23:0] QN_RESET   = 24'd2560;
	localparam logic [23:0] RN_RESET   = 24'd25600;

	localparam logic [16:0] GAIN_ONE = 17'h10000;

	// Configuration register indexes.
	localparam logic [7:0] REG_PPR    = 8'd0;
	localparam logic [7:0] REG_GEAR   = 8'd1;
	localparam logic [7:0] REG_QNOISE = 8'd2;
	localparam logic [7:0] REG_RNOISE = 8'd3;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic div_start;
		logic upd1;
		logic upd2;
		logic upd3;
		logic rad1;
		logic rad2;
	} eske_cmd_t;

	typedef struct packed {
		logic div_done;
	} eske_status_t;

	// Packed so that filtered_rpm sits in the lowest bits.
	typedef struct packed {
		logic [1:0]  turn_sign;
		logic [16:0] kalman_gain;
		logic [31:0] rad_per_sec;
		logic [31:0] raw_rpm;
		logic [31:0] filtered_rpm;
	} eske_result_t;

endpackage

`default_nettype wire

/* design/encoder_speed_kalman_estimator_unit.sv */
// ----------------------------------------------------------------------------
// encoder_speed_kalman_estimator_unit: M/T encoder speed with Kalman filter
// Takes one encoder sample per word, computes raw rpm from the pulse count
// and window length, smooths it with a scalar Kalman filter and returns
// filtered rpm, raw rpm, rad/s, the gain and the held direction.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata: pulse_delta, elapsed_us
// m_*       out  m_tvalid/m_tready   m_tdata: filtered, raw, rad/s, gain, sign
// cfg_*     in   cfg_valid/cfg_ready cfg_addr (register index), cfg_data
//
// Samples are taken one at a time: the input reopens once the result word
// of the last sample is loaded into the output register. The speed divider
// sets the pace of a sample: one quotient bit per cycle over
// 48 + SPEED_FRAC_BITS bits, the gain divider running beside it. A stalled
// result word holds the sequencer in its output step. Reset returns the
// filter state, direction and configuration registers to their reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module encoder_speed_kalman_estimator_unit import eske_pkg::*; #(
	parameter int SPEED_FRAC_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // pulse_delta[15:0], elapsed_us[39:16]
	output logic         m_tvalid,
	input  logic         m_tready,
	// filtered_rpm[31:0], raw_rpm[63:32], rad_per_sec[95:64],
	// kalman_gain[112:96], turn_sign[114:113], zero fill [119:115]
	output logic [119:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_addr,
	input  logic [23:0]  cfg_data
);

	logic [15:0]  ppr_q;
	logic [15:0]  gear_q;
	logic [23:0]  qnoise_q;
	logic [23:0]  rnoise_q;

	logic         m_tvalid_q;
	logic [119:0] m_tdata_q;

	eske_cmd_t    cmd;
	eske_status_t status;
	eske_result_t result;
	logic         in_ready;
	logic         in_fire;
	logic         out_free;
	logic         out_load;

	// Configuration is always accepted; indexes past the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q    <= PPR_RESET;
			gear_q   <= GEAR_RESET;
			qnoise_q <= QN_RESET;
			rnoise_q <= RN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_PPR:    ppr_q    <= cfg_data[15:0];
				REG_GEAR:   gear_q   <= cfg_data[15:0];
				REG_QNOISE: qnoise_q <= cfg_data;
				REG_RNOISE: rnoise_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_fire  = s_tvalid && in_ready;
	assign s_tready = in_ready;

	// The output register frees up in the same cycle its word is taken.
	assign out_free = !m_tvalid_q || m_tready;

	eske_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.out_free(out_free),
		.status  (status),
		.in_ready(in_ready),
		.out_load(out_load),
		.cmd     (cmd)
	);

	eske_datapath #(
		.SPEED_FRAC_BITS(SPEED_FRAC_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.pulse_delta   (s_tdata[15:0]),
		.elapsed_us    (s_tdata[39:16]),
		.pulses_per_rev(ppr_q),
		.gear_div      (gear_q),
		.q_noise       (qnoise_q),
		.r_noise       (rnoise_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {5'd0, result};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

/* design/eske_div.sv */
// ----------------------------------------------------------------------------
// eske_div: bit-serial restoring divider
// Produces one quotient bit per cycle; done stays high until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eske_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 56
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	// The remainder stays below the divisor, so a clear sign bit means it fits.
	assign fits  = ~diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

/* design/eske_ctrl.sv */
// ----------------------------------------------------------------------------
// eske_ctrl: sequencer of the encoder speed estimator
// Steps the datapath via multiply, divide, filter update, rad/s and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eske_ctrl import eske_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_fire,
	input  logic         out_free,
	input  eske_status_t status,
	output logic         in_ready,
	output logic         out_load,
	output eske_cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL1 = 4'd1;
	localparam logic [3:0] ST_MUL2 = 4'd2;
	localparam logic [3:0] ST_DIVS = 4'd3;
	localparam logic [3:0] ST_DIVW = 4'd4;
	localparam logic [3:0] ST_UPD1 = 4'd5;
	localparam logic [3:0] ST_UPD2 = 4'd6;
	localparam logic [3:0] ST_UPD3 = 4'd7;
	localparam logic [3:0] ST_RAD1 = 4'd8;
	localparam logic [3:0] ST_RAD2 = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DIVS;
			ST_DIVS: state_d = ST_DIVW;
			ST_DIVW: if (status.div_done) state_d = ST_UPD1;
			ST_UPD1: state_d = ST_UPD2;
			ST_UPD2: state_d = ST_UPD3;
			ST_UPD3: state_d = ST_RAD1;
			ST_RAD1: state_d = ST_RAD2;
			ST_RAD2: state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_OUT) && out_free;
	assign cmd.load      = in_fire;
	assign cmd.mul1      = (state_q == ST_MUL1);
	assign cmd.mul2      = (state_q == ST_MUL2);
	assign cmd.div_start = (state_q == ST_DIVS);
	assign cmd.upd1      = (state_q == ST_UPD1);
	assign cmd.upd2      = (state_q == ST_UPD2);
	assign cmd.upd3      = (state_q == ST_UPD3);
	assign cmd.rad1      = (state_q == ST_RAD1);
	assign cmd.rad2      = (state_q == ST_RAD2);

endmodule

`default_nettype wire

/* design/eske_datapath.sv */
// ----------------------------------------------------------------------------
// eske_datapath: arithmetic of the encoder speed estimator
// M/T raw speed, scalar Kalman update and rad/s conversion, one step per
// command, with the filter state and the held direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eske_datapath import eske_pkg::*; #(
	parameter int SPEED_FRAC_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  eske_cmd_t    cmd,
	output eske_status_t status,
	input  logic [15:0]  pulse_delta,
	input  logic [23:0]  elapsed_us,
	input  logic [15:0]  pulses_per_rev,
	input  logic [15:0]  gear_div,
	input  logic [23:0]  q_noise,
	input  logic [23:0]  r_noise,
	output eske_result_t result
);

	localparam int NUM_W = 48 + SPEED_FRAC_BITS;
	localparam int DEN_W = 56;
	localparam int GN_W  = 49;
	localparam int GD_W  = 33;

	// Filter state and held direction.
	logic signed [31:0] x_q;
	logic [31:0]        p_q;
	logic [1:0]         dir_q;

	logic [15:0]        mag_q;
	logic [23:0]        el_q;
	logic [31:0]        ppred_q;
	logic [47:0]        num_q;
	logic [39:0]        dena_q;
	logic [GD_W-1:0]    den2_q;
	logic [DEN_W-1:0]   den_q;
	logic [GN_W-1:0]    gnum_q;
	logic signed [31:0] raw_q;
	logic [16:0]        gain_q;
	logic signed [49:0] kprod_q;
	logic [48:0]        vprod_q;
	logic signed [60:0] rprod_q;
	eske_result_t       result_q;

	logic [NUM_W-1:0]   raw_quo;
	logic [GN_W-1:0]    gain_quo;
	logic               raw_done;
	logic               gain_done;

	logic [32:0]        ppred_sum;
	logic [30:0]        raw_mag;
	logic signed [32:0] diff;
	logic signed [49:0] diff_w;
	logic signed [49:0] gain_w;
	logic [49:0]        kmag;
	logic [33:0]        kq;
	logic [33:0]        x_new;
	logic [48:0]        vsum;
	logic signed [60:0] x_w;
	logic signed [60:0] pi_w;
	logic [60:0]        rmag;
	logic [60:0]        rsum;
	logic [31:0]        rq;

	eske_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_raw_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   ({num_q, {SPEED_FRAC_BITS{1'b0}}}),
		.den   (den_q),
		.done  (raw_done),
		.quo   (raw_quo)
	);

	eske_div #(
		.NUM_W(GN_W),
		.DEN_W(GD_W)
	) u_gain_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (gnum_q),
		.den   (den2_q),
		.done  (gain_done),
		.quo   (gain_quo)
	);

	assign status.div_done = raw_done & gain_done;

	always_comb begin
		ppred_sum = {1'b0, p_q} + {9'd0, q_noise};
		raw_mag   = (|raw_quo[NUM_W-1:31]) ? 31'h7FFFFFFF : raw_quo[30:0];
		diff      = {raw_q[31], raw_q} - {x_q[31], x_q};
		diff_w    = {{17{diff[32]}}, diff};
		gain_w    = {33'd0, gain_q};
		kmag      = kprod_q[49] ? 50'(-kprod_q) : 50'(kprod_q);
		kq        = 34'((kmag + 50'd32768) >> 16);
		x_new     = {{2{x_q[31]}}, x_q} + (kprod_q[49] ? 34'(-kq) : kq);
		vsum      = vprod_q + 49'd32768;
		x_w       = {{29{x_q[31]}}, x_q};
		pi_w      = {32'd0, PI_OVER_30_Q32};
		rmag      = rprod_q[60] ? 61'(-rprod_q) : 61'(rprod_q);
		rsum      = rmag + 61'h80000000;
		rq        = {3'd0, rsum[60:32]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			p_q   <= VAR_RESET;
			dir_q <= 2'b00;
		end else begin
			if (cmd.load && (pulse_delta != 16'd0)) begin
				dir_q <= pulse_delta[15] ? 2'b11 : 2'b01;
			end
			if (cmd.upd3) begin
				x_q <= x_new[31:0];
				p_q <= vsum[47:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q   <= pulse_delta[15] ? 16'(-pulse_delta) : pulse_delta;
			el_q    <= elapsed_us;
			ppred_q <= ppred_sum[32] ? 32'hFFFFFFFF : ppred_sum[31:0];
		end
		if (cmd.mul1) begin
			num_q  <= {32'd0, mag_q} * {16'd0, RPM_NUM};
			dena_q <= {24'd0, pulses_per_rev} * {16'd0, el_q};
			den2_q <= {1'b0, ppred_q} + {9'd0, r_noise};
		end
		if (cmd.mul2) begin
			den_q  <= {16'd0, dena_q} * {40'd0, gear_div};
			gnum_q <= {1'b0, ppred_q, 16'd0} + {17'd0, den2_q[32:1]};
		end
		if (cmd.upd1) begin
			// A zero window, ppr or gear gives a zero divisor and zero speed.
			if (den_q == '0) begin
				raw_q <= '0;
			end else begin
				unique case (dir_q)
					2'b01:   raw_q <= {1'b0, raw_mag};
					2'b11:   raw_q <= -{1'b0, raw_mag};
					default: raw_q <= '0;
				endcase
			end
			if (den2_q == '0) begin
				gain_q <= '0;
			end else if (gain_quo > GN_W'(GAIN_ONE)) begin
				gain_q <= GAIN_ONE;
			end else begin
				gain_q <= gain_quo[16:0];
			end
		end
		if (cmd.upd2) begin
			kprod_q <= diff_w * gain_w;
			vprod_q <= {32'd0, 17'(GAIN_ONE - gain_q)} * {17'd0, ppred_q};
		end
		if (cmd.rad1) begin
			rprod_q <= x_w * pi_w;
		end
		if (cmd.rad2) begin
			result_q.filtered_rpm <= x_q;
			result_q.raw_rpm      <= raw_q;
			result_q.rad_per_sec  <= rprod_q[60] ? 32'(-rq) : rq;
			result_q.kalman_gain  <= gain_q;
			result_q.turn_sign    <= dir_q;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

/* design/eske_checker.sv */
// ----------------------------------------------------------------------------
// eske_checker: port-level checks of the encoder speed estimator
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eske_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata
);

	// A word that is not taken stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// One sample at a time: the input closes right after an acceptance.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still open after acceptance");

	// The gain never exceeds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[112] && (m_tdata[111:96] != 16'd0)))
		else $error("gain above one");

	// The held direction is one, minus one or zero, and the fill is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[114:113] != 2'b10) && (m_tdata[119:115] == 5'd0))
		else $error("bad direction code or fill bits");

endmodule

bind encoder_speed_kalman_estimator_unit eske_checker u_eske_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
